FILE: rtl/animation_phase_generator_unit_assert.svh
// assertion helpers for the animation phase generator
`ifndef ANIMATION_PHASE_GENERATOR_UNIT_ASSERT_SVH
`define ANIMATION_PHASE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define APG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define APG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/apg_pkg.sv
package apg_pkg;

  localparam int DATA_W    = 32;
  localparam int TICK_W    = 32;
  localparam int DUR_W     = 32;
  localparam int FRM_W     = 16;
  localparam int RC_W      = 32;
  localparam int FRAC_W    = 16;
  localparam int WHOLE_W   = 16;
  localparam int REL_W     = 17;
  localparam int IDX_W     = 16;
  localparam int LAG_W     = 32;
  localparam int DVD_W     = TICK_W + FRAC_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int MUL_STEPS = DATA_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_VALID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_REVERSE = 3'd4;

  localparam logic [DUR_W-1:0] MIN_DURATION_RST = 32'd1000;
  localparam logic [FRM_W-1:0] MIN_FRAMES_RST   = 16'd10;
  localparam logic [RC_W-1:0]  REPEAT_COUNT_RST = 32'h0001_0000;

  localparam logic [REL_W-1:0] ONE_Q16 = 17'h1_0000;

  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_LAG   = 1'b1;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              ovf;
    logic [DUR_W-1:0]  quot;
  } div_res_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_res_t;

endpackage

FILE: rtl/apg_in_if.sv
interface apg_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [apg_pkg::TICK_W-1:0] elapsed_ticks;

  modport source (output valid, output mode, output elapsed_ticks, input ready);
  modport sink (input valid, input mode, input elapsed_ticks, output ready);
endinterface

FILE: rtl/apg_out_if.sv
interface apg_out_if;
  logic                       valid;
  logic                       ready;
  logic                       performed;
  logic [apg_pkg::REL_W-1:0]  relative_time;
  logic [apg_pkg::IDX_W-1:0]  repeat_index;
  logic                       ending;
  logic                       still_active;
  logic [apg_pkg::LAG_W-1:0]  time_lag;

  modport source (
    output valid, output performed, output relative_time, output repeat_index,
    output ending, output still_active, output time_lag, input ready
  );
  modport sink (
    input valid, input performed, input relative_time, input repeat_index,
    input ending, input still_active, input time_lag, output ready
  );
endinterface

FILE: rtl/animation_phase_generator_unit.sv
// Animation phase generator. Each input transfer carries an elapsed tick count and a mode.
// Frame mode returns the position inside the current period (Q1.16, 65536 = 1.0), the
// repeat index and the ending flag, and clears the active state once the finite repeat
// count is reached. Lag mode returns how many ticks the global clock must hold back so
// that min_frames frames fit in one period. One item is in flight at a time. A frame
// item runs through the bit-serial 48-step divider for elapsed * 65536 / min_duration,
// then the finish states. A lag item runs two 32-step serial multipliers side by side,
// a subtract state, then the same divider; a lag query whose difference is negative
// skips the divider and returns a lag of zero. Frame items after the animation has
// ended, lag queries while inactive or with min_frames zero go straight to the output
// without arithmetic. A finished result waits in the output register, so the next item
// is taken while it is pending. Registers sit at byte addresses 4*i and must only be
// written while no item is in flight.
`include "animation_phase_generator_unit_assert.svh"

module animation_phase_generator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  apg_in_if.sink                            in_ch,
  apg_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [apg_pkg::DATA_W-1:0]        pwdata,
  output logic [apg_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SUB  = 3'd3;
  localparam logic [2:0] ST_FIN1 = 3'd4;
  localparam logic [2:0] ST_FIN2 = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  // configuration
  logic [apg_pkg::DUR_W-1:0]     min_dur_r;
  logic [apg_pkg::FRM_W-1:0]     min_frm_r;
  logic                          rep_valid_r;
  logic [apg_pkg::RC_W-1:0]      rep_cnt_r;
  logic                          auto_rev_r;
  logic [apg_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                          cfg_wr;

  // control
  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  logic                          mode_r;
  logic                          active_r;
  logic [apg_pkg::DATA_W-1:0]    frame_cnt_r;
  logic                          out_valid_r;
  logic                          in_acc;
  logic                          out_load;

  // datapath
  logic [apg_pkg::DUR_W-1:0]     t_r;
  logic                          ending_r;
  logic                          res_perf_r;
  logic [apg_pkg::REL_W-1:0]     res_rel_r;
  logic [apg_pkg::IDX_W-1:0]     res_idx_r;
  logic                          res_end_r;
  logic                          res_act_r;
  logic [apg_pkg::LAG_W-1:0]     res_lag_r;
  logic                          out_perf_r;
  logic [apg_pkg::REL_W-1:0]     out_rel_r;
  logic [apg_pkg::IDX_W-1:0]     out_idx_r;
  logic                          out_end_r;
  logic                          out_act_r;
  logic [apg_pkg::LAG_W-1:0]     out_lag_r;

  logic                          div_start;
  logic [apg_pkg::DVD_W-1:0]     div_dvd;
  logic [apg_pkg::DUR_W-1:0]     div_dsr;
  apg_pkg::div_res_t             div_res;
  logic                          mul_start;
  apg_pkg::mul_res_t             mul_a_res;
  apg_pkg::mul_res_t             mul_b_res;
  logic [apg_pkg::PROD_W:0]      diff;

  logic [apg_pkg::RC_W:0]        eff;
  logic                          hit;
  logic [apg_pkg::WHOLE_W-1:0]   whole;
  logic [apg_pkg::FRAC_W-1:0]    frac;
  logic                          last_rep;
  logic [apg_pkg::REL_W-1:0]     fin_rel;
  logic [apg_pkg::IDX_W-1:0]     fin_idx;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[apg_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dur_r   <= apg_pkg::MIN_DURATION_RST;
      min_frm_r   <= apg_pkg::MIN_FRAMES_RST;
      rep_valid_r <= 1'b0;
      rep_cnt_r   <= apg_pkg::REPEAT_COUNT_RST;
      auto_rev_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        apg_pkg::REG_MIN_DURATION: min_dur_r   <= pwdata;
        apg_pkg::REG_MIN_FRAMES:   min_frm_r   <= pwdata[apg_pkg::FRM_W-1:0];
        apg_pkg::REG_REPEAT_VALID: rep_valid_r <= pwdata[0];
        apg_pkg::REG_REPEAT_COUNT: rep_cnt_r   <= pwdata;
        apg_pkg::REG_AUTO_REVERSE: auto_rev_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      apg_pkg::REG_MIN_DURATION: prdata = min_dur_r;
      apg_pkg::REG_MIN_FRAMES:   prdata = {{(apg_pkg::DATA_W-apg_pkg::FRM_W){1'b0}}, min_frm_r};
      apg_pkg::REG_REPEAT_VALID: prdata = {{(apg_pkg::DATA_W-1){1'b0}}, rep_valid_r};
      apg_pkg::REG_REPEAT_COUNT: prdata = rep_cnt_r;
      apg_pkg::REG_AUTO_REVERSE: prdata = {{(apg_pkg::DATA_W-1){1'b0}}, auto_rev_r};
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- arithmetic units
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // ticks*frames - frame_count*duration; lag = floor(difference / frames)
  assign diff = {1'b0, mul_a_res.prod} - {1'b0, mul_b_res.prod};

  assign mul_start = in_acc && (in_ch.mode == apg_pkg::MODE_LAG) && active_r
                  && (min_frm_r != '0);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {in_ch.elapsed_ticks, {apg_pkg::FRAC_W{1'b0}}};
    div_dsr   = min_dur_r;
    if (in_acc && (in_ch.mode == apg_pkg::MODE_FRAME) && active_r) begin
      div_start = 1'b1;
    end else if ((state_r == ST_SUB) && !diff[apg_pkg::PROD_W]) begin
      div_start = 1'b1;
      div_dvd   = diff[apg_pkg::DVD_W-1:0];
      div_dsr   = {{(apg_pkg::DUR_W-apg_pkg::FRM_W){1'b0}}, min_frm_r};
    end
  end

  apg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .res      (div_res)
  );

  apg_mul u_mul_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (in_ch.elapsed_ticks),
    .mplier ({{(apg_pkg::DATA_W-apg_pkg::FRM_W){1'b0}}, min_frm_r}),
    .res    (mul_a_res)
  );

  apg_mul u_mul_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (min_dur_r),
    .mplier (frame_cnt_r),
    .res    (mul_b_res)
  );

  // ---------------------------------------------------------------- frame finish logic
  always_comb begin
    eff = auto_rev_r ? {rep_cnt_r, 1'b0} : {1'b0, rep_cnt_r};
    hit = rep_valid_r && (eff <= {1'b0, t_r});

    whole = t_r[apg_pkg::DUR_W-1:apg_pkg::FRAC_W];
    frac  = t_r[apg_pkg::FRAC_W-1:0];
    // whole * 65536 >= repeat_count
    last_rep = rep_valid_r
            && ((whole > rep_cnt_r[apg_pkg::RC_W-1:apg_pkg::FRAC_W])
             || ((whole == rep_cnt_r[apg_pkg::RC_W-1:apg_pkg::FRAC_W])
              && (rep_cnt_r[apg_pkg::FRAC_W-1:0] == '0)));

    if (auto_rev_r) begin
      fin_rel = whole[0] ? (apg_pkg::ONE_Q16 - {1'b0, frac}) : {1'b0, frac};
      fin_idx = {1'b0, whole[apg_pkg::WHOLE_W-1:1]};
    end else if (last_rep) begin
      fin_rel = apg_pkg::ONE_Q16;
      fin_idx = (whole == '0) ? '0 : (whole - 1'b1);
    end else begin
      fin_rel = {1'b0, frac};
      fin_idx = whole;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (div_start) begin
            state_nxt = ST_DIV;
          end else if (mul_start) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = (mode_r == apg_pkg::MODE_FRAME) ? ST_FIN1 : ST_EMIT;
        end
      end
      ST_MUL: begin
        if (mul_a_res.done) begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB:  state_nxt = diff[apg_pkg::PROD_W] ? ST_EMIT : ST_DIV;
      ST_FIN1: state_nxt = ST_FIN2;
      ST_FIN2: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= apg_pkg::MODE_FRAME;
      active_r    <= 1'b1;
      frame_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        mode_r <= in_ch.mode;
      end
      if (state_r == ST_FIN2) begin
        if (ending_r) begin
          active_r <= 1'b0;
        end
        if (frame_cnt_r != '1) begin
          frame_cnt_r <= frame_cnt_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        res_perf_r <= 1'b0;
        res_rel_r  <= '0;
        res_idx_r  <= '0;
        res_end_r  <= 1'b0;
        res_act_r  <= active_r;
        res_lag_r  <= '0;
      end
      ST_DIV: begin
        if (div_res.done) begin
          t_r       <= div_res.ovf ? '1 : div_res.quot;
          res_lag_r <= div_res.quot;
        end
      end
      ST_FIN1: begin
        ending_r <= hit;
        if (hit) begin
          t_r <= eff[apg_pkg::DUR_W-1:0];
        end
      end
      ST_FIN2: begin
        res_perf_r <= 1'b1;
        res_rel_r  <= fin_rel;
        res_idx_r  <= fin_idx;
        res_end_r  <= ending_r;
        res_act_r  <= !ending_r;
        res_lag_r  <= '0;
      end
      default: ;
    endcase
    if (out_load) begin
      out_perf_r <= res_perf_r;
      out_rel_r  <= res_rel_r;
      out_idx_r  <= res_idx_r;
      out_end_r  <= res_end_r;
      out_act_r  <= res_act_r;
      out_lag_r  <= res_lag_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.performed     = out_perf_r;
  assign out_ch.relative_time = out_rel_r;
  assign out_ch.repeat_index  = out_idx_r;
  assign out_ch.ending        = out_end_r;
  assign out_ch.still_active  = out_act_r;
  assign out_ch.time_lag      = out_lag_r;

  // ---------------------------------------------------------------- checks
  `APG_ASSERT_NOW(a_idle_units_quiet, state_r == ST_IDLE,
    !div_res.busy && !mul_a_res.busy && !mul_b_res.busy, "arithmetic unit busy while idle")
  `APG_ASSERT_NOW(a_div_done_in_div, div_res.done, state_r == ST_DIV,
    "divider finished outside divide state")
  `APG_ASSERT_NOW(a_mul_in_step, mul_a_res.done || mul_b_res.done,
    mul_a_res.done && mul_b_res.done && (state_r == ST_MUL), "multipliers out of step")
  `APG_ASSERT_NEXT(a_active_sticky, !active_r, !active_r,
    "ended animation became active again")

endmodule

FILE: rtl/apg_div.sv
module apg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [apg_pkg::DVD_W-1:0]   dividend,
  input  logic [apg_pkg::DUR_W-1:0]   divisor,
  output apg_pkg::div_res_t           res
);

  logic [apg_pkg::DVD_W-1:0]     dvd_r;
  logic [apg_pkg::DUR_W-1:0]     dsr_r;
  logic [apg_pkg::DUR_W-1:0]     rem_r;
  logic [apg_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic                          last;
  logic                          nxt_bit;
  logic [apg_pkg::DUR_W+1:0]     trial;
  logic                          ge;

  // restoring division, one quotient bit per cycle shifted into the dividend register
  always_comb begin
    nxt_bit = dvd_r[apg_pkg::DVD_W-1];
    trial   = {1'b0, rem_r, nxt_bit} - {2'b00, dsr_r};
    ge      = ~trial[apg_pkg::DUR_W+1];
    last    = (cnt_r == apg_pkg::DIV_CNT_W'(apg_pkg::DIV_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? trial[apg_pkg::DUR_W-1:0] : {rem_r[apg_pkg::DUR_W-2:0], nxt_bit};
      dvd_r <= {dvd_r[apg_pkg::DVD_W-2:0], ge};
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.ovf  = |dvd_r[apg_pkg::DVD_W-1:apg_pkg::DUR_W];
  assign res.quot = dvd_r[apg_pkg::DUR_W-1:0];

endmodule

FILE: rtl/apg_mul.sv
module apg_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [apg_pkg::DATA_W-1:0]   mcand,
  input  logic [apg_pkg::DATA_W-1:0]   mplier,
  output apg_pkg::mul_res_t            res
);

  logic [apg_pkg::PROD_W-1:0]    prod_r;
  logic [apg_pkg::DATA_W-1:0]    mcand_r;
  logic [apg_pkg::MUL_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic                          last;
  logic [apg_pkg::DATA_W:0]      sum;

  // shift-add: multiplier bits leave at the bottom, partial sum enters at the top
  always_comb begin
    sum  = {1'b0, prod_r[apg_pkg::PROD_W-1:apg_pkg::DATA_W]}
         + {1'b0, (prod_r[0] ? mcand_r : '0)};
    last = (cnt_r == apg_pkg::MUL_CNT_W'(apg_pkg::MUL_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r  <= {{apg_pkg::DATA_W{1'b0}}, mplier};
      mcand_r <= mcand;
    end else if (busy_r) begin
      prod_r <= {sum, prod_r[apg_pkg::DATA_W-1:1]};
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.prod = prod_r;

endmodule
